// ===== rtl/qou_pkg.sv =====
// shared types, constants and lookup functions for the quaternion orientation unit
// no dependencies; every other rtl file except qou_checker imports this package
package qou_pkg;

    // component and arithmetic widths
    localparam int QW    = 16;            // q2.14 component
    localparam int NCOMP = 4;             // w, x, y, z
    localparam int AW    = 34;            // hamilton product accumulator
    localparam int TW    = 31;            // truncated magnitude
    localparam int SQW   = 2 * TW;        // one square
    localparam int SW    = 64;            // sum of squares and root registers
    localparam int LW    = 32;            // root (length)
    localparam int QB    = 17;            // quotient bits, quotient never exceeds 2^14
    localparam int NW    = TW + 15;       // division numerator
    localparam int FRAC  = 14;            // fraction bits of q2.14

    // sequencer step counts
    localparam int CW        = 6;
    localparam int MAC_LAST  = 16;
    localparam int SQ_LAST   = 4;
    localparam int ROOT_LAST = 32;
    localparam int DIV_LAST  = QB + 1;

    typedef logic signed [QW-1:0] q_t;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_LOCAL  = 3'd1,
        OP_GLOBAL = 3'd2,
        OP_ROTATE = 3'd3,
        OP_CONJ   = 3'd4,
        OP_NEGATE = 3'd5,
        OP_NORM   = 3'd6,
        OP_NONE   = 3'd7
    } op_t;

    // operand selection for a hamilton product
    typedef enum logic [1:0] {
        AB_QORI,   // in * orientation
        AB_ORIQ,   // orientation * in
        AB_CONV,   // conj(orientation) * (0, vector)
        AB_TORI    // first rotate product * orientation
    } ab_sel_t;

    typedef enum logic [1:0] {
        DST_NONE,
        DST_ORI,
        DST_VEC
    } dst_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIMPLE,
        ST_SETUP,
        ST_MAC,
        ST_NORM_LD,
        ST_PREP,
        ST_SQ,
        ST_ROOT,
        ST_DIV,
        ST_COMMIT,
        ST_DONE
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       cap_in;
        logic       simple;
        op_t        simple_op;
        logic       ld_ab;
        ab_sel_t    ab_sel;
        logic       mac_mul;
        logic [3:0] mul_term;
        logic       mac_acc;
        logic [3:0] acc_term;
        logic       ld_norm;
        logic       prep;
        logic       sq_mul;
        logic       sq_acc;
        logic [1:0] sq_idx;
        logic       root_init;
        logic       root_step;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic [1:0] comp;
        dst_t       commit;
        logic       out_load;
    } dp_cmd_t;

    // hamilton product term table: {a index, b index, subtract}
    function automatic logic [4:0] term_info(input logic [3:0] k);
        logic [4:0] r;
        case (k)
            4'd0:    r = {2'd0, 2'd0, 1'b0};
            4'd1:    r = {2'd1, 2'd1, 1'b1};
            4'd2:    r = {2'd2, 2'd2, 1'b1};
            4'd3:    r = {2'd3, 2'd3, 1'b1};
            4'd4:    r = {2'd0, 2'd1, 1'b0};
            4'd5:    r = {2'd1, 2'd0, 1'b0};
            4'd6:    r = {2'd2, 2'd3, 1'b0};
            4'd7:    r = {2'd3, 2'd2, 1'b1};
            4'd8:    r = {2'd0, 2'd2, 1'b0};
            4'd9:    r = {2'd2, 2'd0, 1'b0};
            4'd10:   r = {2'd3, 2'd1, 1'b0};
            4'd11:   r = {2'd1, 2'd3, 1'b1};
            4'd12:   r = {2'd0, 2'd3, 1'b0};
            4'd13:   r = {2'd3, 2'd0, 1'b0};
            4'd14:   r = {2'd1, 2'd2, 1'b0};
            default: r = {2'd2, 2'd1, 1'b1};
        endcase
        return r;
    endfunction

    // negate with saturation of the most negative value
    function automatic q_t neg_sat(input q_t v);
        q_t r;
        if (v == q_t'(-32768))
            r = q_t'(32767);
        else
            r = -v;
        return r;
    endfunction

endpackage

// ===== rtl/qou_datapath.sv =====
// datapath of the quaternion orientation unit: orientation state, product mac,
// sum of squares, bit-pair square root and restoring divider; depends on qou_pkg
module qou_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  qou_pkg::q_t       in_w,
    input  qou_pkg::q_t       in_x,
    input  qou_pkg::q_t       in_y,
    input  qou_pkg::q_t       in_z,
    input  qou_pkg::dp_cmd_t  cmd,
    output logic [111:0]      out_data   // ori_w, ori_x, ori_y, ori_z, vec_x, vec_y, vec_z
);
    import qou_pkg::*;

    q_t                   q_reg    [NCOMP];
    q_t                   q_next   [NCOMP];
    q_t                   ori_reg  [NCOMP];
    q_t                   ori_next [NCOMP];
    q_t                   vec_reg  [3];
    q_t                   vec_next [3];
    q_t                   a_reg    [NCOMP];
    q_t                   a_next   [NCOMP];
    q_t                   b_reg    [NCOMP];
    q_t                   b_next   [NCOMP];
    q_t                   nres_reg [NCOMP];
    q_t                   nres_next[NCOMP];
    logic signed [AW-1:0] r_reg    [NCOMP];
    logic signed [AW-1:0] r_next   [NCOMP];
    logic [TW-1:0]        t_reg    [NCOMP];
    logic [TW-1:0]        t_next   [NCOMP];
    logic [NCOMP-1:0]     neg_reg, neg_next;
    logic signed [31:0]   prod_reg, prod_next;
    logic [SQW-1:0]       sq_reg, sq_next;
    logic [SW-1:0]        sum_reg, sum_next;
    logic [SW-1:0]        n_reg, n_next;
    logic [SW-1:0]        res_reg, res_next;
    logic [SW-1:0]        bit_reg, bit_next;
    logic [LW:0]          rem_reg, rem_next;
    logic [QB-1:0]        low_reg, low_next;
    logic [QB-1:0]        quo_reg, quo_next;
    logic [111:0]         out_reg, out_next;

    logic [4:0]           mul_info, acc_info;
    logic [1:0]           acc_comp;
    logic [LW-1:0]        len;
    logic [SW-1:0]        trial;
    logic [NW-1:0]        num;
    logic [LW:0]          shifted;
    logic signed [AW-1:0] prod_ext;
    logic [AW-1:0]        mag;
    q_t                   qmag;

    assign mul_info = term_info(cmd.mul_term);
    assign acc_info = term_info(cmd.acc_term);
    assign acc_comp = cmd.acc_term[3:2];
    assign len      = res_reg[LW-1:0];
    assign trial    = res_reg + bit_reg;
    assign num      = {t_reg[cmd.comp], {FRAC{1'b0}}} + NW'(len >> 1);
    assign shifted  = {rem_reg[LW-1:0], low_reg[QB-1]};
    assign prod_ext = AW'(prod_reg);
    assign qmag     = q_t'(quo_reg[QW-1:0]);
    assign out_data = out_reg;

    // next-value logic for all datapath registers
    always_comb
    begin
        q_next    = q_reg;
        ori_next  = ori_reg;
        vec_next  = vec_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        nres_next = nres_reg;
        r_next    = r_reg;
        t_next    = t_reg;
        neg_next  = neg_reg;
        prod_next = prod_reg;
        sq_next   = sq_reg;
        sum_next  = sum_reg;
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        out_next  = out_reg;
        mag       = '0;

        // capture an accepted item
        if (cmd.cap_in)
        begin
            q_next[0] = in_w;
            q_next[1] = in_x;
            q_next[2] = in_y;
            q_next[3] = in_z;
            for (int i = 0; i < 3; i++)
                vec_next[i] = '0;
        end

        // simple operations: load, conjugate, negate
        if (cmd.simple)
        begin
            case (cmd.simple_op)
                OP_LOAD:
                    ori_next = q_reg;
                OP_CONJ:
                    for (int i = 1; i < NCOMP; i++)
                        ori_next[i] = neg_sat(ori_reg[i]);
                OP_NEGATE:
                    for (int i = 0; i < NCOMP; i++)
                        ori_next[i] = neg_sat(ori_reg[i]);
                default:
                    ;
            endcase
        end

        // operand load for a product
        if (cmd.ld_ab)
        begin
            case (cmd.ab_sel)
                AB_QORI:
                begin
                    a_next = q_reg;
                    b_next = ori_reg;
                end
                AB_ORIQ:
                begin
                    a_next = ori_reg;
                    b_next = q_reg;
                end
                AB_CONV:
                begin
                    a_next[0] = ori_reg[0];
                    for (int i = 1; i < NCOMP; i++)
                        a_next[i] = neg_sat(ori_reg[i]);
                    b_next    = q_reg;
                    b_next[0] = '0;
                end
                default:
                begin
                    a_next = nres_reg;
                    b_next = ori_reg;
                end
            endcase
            for (int i = 0; i < NCOMP; i++)
                r_next[i] = '0;
        end

        // one partial product per cycle, accumulated the cycle after
        if (cmd.mac_mul)
            prod_next = a_reg[mul_info[4:3]] * b_reg[mul_info[2:1]];
        if (cmd.mac_acc)
        begin
            if (acc_info[0])
                r_next[acc_comp] = r_reg[acc_comp] - prod_ext;
            else
                r_next[acc_comp] = r_reg[acc_comp] + prod_ext;
        end

        // normalize op starts from the stored orientation scaled up, sign kept
        if (cmd.ld_norm)
            for (int i = 0; i < NCOMP; i++)
                r_next[i] = AW'(signed'({ori_reg[i], {FRAC{1'b0}}}));

        // magnitudes truncated by two bits
        if (cmd.prep)
        begin
            for (int i = 0; i < NCOMP; i++)
            begin
                neg_next[i] = r_reg[i][AW-1];
                mag         = r_reg[i][AW-1] ? AW'(-r_reg[i]) : AW'(r_reg[i]);
                t_next[i]   = TW'(mag >> 2);
            end
            sum_next = '0;
        end

        // sum of squares
        if (cmd.sq_mul)
            sq_next = t_reg[cmd.sq_idx] * t_reg[cmd.sq_idx];
        if (cmd.sq_acc)
            sum_next = sum_reg + SW'(sq_reg);

        // square root, one result bit per cycle
        if (cmd.root_init)
        begin
            n_next   = sum_reg;
            res_next = '0;
            bit_next = SW'(1) << 62;
        end
        if (cmd.root_step)
        begin
            if (n_reg >= trial)
            begin
                n_next   = n_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
                res_next = res_reg >> 1;
            bit_next = bit_reg >> 2;
        end

        // rounded division by the length, one quotient bit per cycle
        if (cmd.div_init)
        begin
            rem_next = (LW+1)'(num[NW-1:QB]);
            low_next = num[QB-1:0];
            quo_next = '0;
        end
        if (cmd.div_step)
        begin
            if (shifted >= {1'b0, len})
            begin
                rem_next = shifted - {1'b0, len};
                quo_next = {quo_reg[QB-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[QB-2:0], 1'b0};
            end
            low_next = {low_reg[QB-2:0], 1'b0};
        end
        if (cmd.div_store)
        begin
            if (len == '0)
                nres_next[cmd.comp] = '0;
            else if (neg_reg[cmd.comp])
                nres_next[cmd.comp] = -qmag;
            else
                nres_next[cmd.comp] = qmag;
        end

        // write back the normalized value
        case (cmd.commit)
            DST_ORI:
                ori_next = nres_reg;
            DST_VEC:
                for (int i = 0; i < 3; i++)
                    vec_next[i] = nres_reg[i+1];
            default:
                ;
        endcase

        // result register toward the output channel
        if (cmd.out_load)
            out_next = {vec_reg[2], vec_reg[1], vec_reg[0],
                        ori_reg[3], ori_reg[2], ori_reg[1], ori_reg[0]};
    end

    // orientation state, identity after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ori_reg[0] <= q_t'(1 << FRAC);
            for (int i = 1; i < NCOMP; i++)
                ori_reg[i] <= '0;
        end
        else
            ori_reg <= ori_next;
    end

    // working registers
    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        vec_reg  <= vec_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        nres_reg <= nres_next;
        r_reg    <= r_next;
        t_reg    <= t_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        sq_reg   <= sq_next;
        sum_reg  <= sum_next;
        n_reg    <= n_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quo_reg  <= quo_next;
        out_reg  <= out_next;
    end

endmodule

// ===== rtl/qou_controller.sv =====
// controller of the quaternion orientation unit: sequences the datapath and
// runs the stream handshakes; depends on qou_pkg
module qou_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  qou_pkg::op_t      in_op,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output qou_pkg::dp_cmd_t  cmd
);
    import qou_pkg::*;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    comp_reg, comp_next;
    logic          pass_reg, pass_next;
    op_t           op_reg, op_next;
    logic          valid_reg, valid_next;
    logic [CW-1:0] cnt_m1;
    logic          take;
    logic          emit;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = valid_reg;
    assign take      = in_valid && in_ready;
    assign emit      = (state_reg == ST_DONE) && (!valid_reg || out_ready);
    assign cnt_m1    = cnt_reg - CW'(1);

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        pass_next  = pass_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_IDLE:
                if (take)
                begin
                    op_next   = in_op;
                    pass_next = 1'b0;
                    case (in_op) inside
                        OP_LOCAL, OP_GLOBAL, OP_ROTATE: state_next = ST_SETUP;
                        OP_NORM:                        state_next = ST_NORM_LD;
                        default:                        state_next = ST_SIMPLE;
                    endcase
                end
            ST_SIMPLE:
                state_next = ST_DONE;
            ST_SETUP:
            begin
                cnt_next   = '0;
                state_next = ST_MAC;
            end
            ST_MAC:
                if (cnt_reg == CW'(MAC_LAST))
                    state_next = ST_PREP;
                else
                    cnt_next = cnt_reg + CW'(1);
            ST_NORM_LD:
                state_next = ST_PREP;
            ST_PREP:
            begin
                cnt_next   = '0;
                state_next = ST_SQ;
            end
            ST_SQ:
                if (cnt_reg == CW'(SQ_LAST))
                begin
                    cnt_next   = '0;
                    state_next = ST_ROOT;
                end
                else
                    cnt_next = cnt_reg + CW'(1);
            ST_ROOT:
                if (cnt_reg == CW'(ROOT_LAST))
                begin
                    cnt_next   = '0;
                    comp_next  = '0;
                    state_next = ST_DIV;
                end
                else
                    cnt_next = cnt_reg + CW'(1);
            ST_DIV:
                if (cnt_reg == CW'(DIV_LAST))
                begin
                    cnt_next  = '0;
                    comp_next = comp_reg + 2'd1;
                    if (comp_reg == 2'd3)
                    begin
                        if (op_reg == OP_ROTATE && !pass_reg)
                        begin
                            pass_next  = 1'b1;
                            state_next = ST_SETUP;
                        end
                        else
                            state_next = ST_COMMIT;
                    end
                end
                else
                    cnt_next = cnt_reg + CW'(1);
            ST_COMMIT:
                state_next = ST_DONE;
            ST_DONE:
                if (emit)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // output valid, held until the receiver takes the transfer
    always_comb
    begin
        valid_next = valid_reg;
        if (emit)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    // datapath commands
    always_comb
    begin
        cmd           = '0;
        cmd.simple_op = op_reg;
        cmd.mul_term  = cnt_reg[3:0];
        cmd.acc_term  = cnt_m1[3:0];
        cmd.sq_idx    = cnt_reg[1:0];
        cmd.comp      = comp_reg;
        cmd.ab_sel    = AB_QORI;
        cmd.commit    = DST_NONE;
        unique case (state_reg)
            ST_IDLE:
                cmd.cap_in = take;
            ST_SIMPLE:
                cmd.simple = 1'b1;
            ST_SETUP:
            begin
                cmd.ld_ab = 1'b1;
                case (op_reg)
                    OP_GLOBAL: cmd.ab_sel = AB_ORIQ;
                    OP_ROTATE: cmd.ab_sel = pass_reg ? AB_TORI : AB_CONV;
                    default:   cmd.ab_sel = AB_QORI;
                endcase
            end
            ST_MAC:
            begin
                cmd.mac_mul = (cnt_reg < CW'(MAC_LAST));
                cmd.mac_acc = (cnt_reg != '0);
            end
            ST_NORM_LD:
                cmd.ld_norm = 1'b1;
            ST_PREP:
                cmd.prep = 1'b1;
            ST_SQ:
            begin
                cmd.sq_mul = (cnt_reg < CW'(SQ_LAST));
                cmd.sq_acc = (cnt_reg != '0);
            end
            ST_ROOT:
            begin
                cmd.root_init = (cnt_reg == '0);
                cmd.root_step = (cnt_reg != '0);
            end
            ST_DIV:
            begin
                cmd.div_init  = (cnt_reg == '0);
                cmd.div_store = (cnt_reg == CW'(DIV_LAST));
                cmd.div_step  = !cmd.div_init && !cmd.div_store;
            end
            ST_COMMIT:
                cmd.commit = (op_reg == OP_ROTATE) ? DST_VEC : DST_ORI;
            ST_DONE:
                cmd.out_load = emit;
            default:
                ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
            pass_reg  <= 1'b0;
            op_reg    <= OP_NONE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
            pass_reg  <= pass_next;
            op_reg    <= op_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== rtl/quaternion_orientation_unit.sv =====
// top level of the quaternion orientation unit: stream ports, controller and datapath
// depends on qou_pkg, qou_controller and qou_datapath
//
// Keeps one orientation quaternion in q2.14 and applies one operation per input
// transfer: load, compose on either side, rotate a vector, conjugate, negate or
// normalize. Each input transfer gives exactly one output transfer carrying the
// orientation after the step and, for a rotate, the rotated vector (zero otherwise).
// Items are processed one at a time; s_axis_tready is high only while the unit idles.
// The next input transfer can come in the same cycle as output valid rises.
// Each product runs its terms through one shared 16x16 multiplier; then the sum of
// squares, the square root (one bit per cycle) and the four rounded divides (one
// quotient bit per cycle each) normalize the result.
// The result waits in an output register; the next item is accepted while it waits,
// and that item's result stalls until the receiver takes the previous one.
// Reset puts the orientation to identity (w one, others zero) and clears the output valid.
module quaternion_orientation_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [71:0]   s_axis_tdata,   // op[2:0], in_w, in_x, in_y, in_z, zero pad
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [111:0]  m_axis_tdata    // ori_w, ori_x, ori_y, ori_z, vec_x, vec_y, vec_z
);
    import qou_pkg::*;

    dp_cmd_t cmd;
    op_t     in_op;

    assign in_op = op_t'(s_axis_tdata[2:0]);

    // sequencing and handshakes
    qou_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_op     (in_op),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    // arithmetic and state
    qou_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_w     (q_t'(s_axis_tdata[18:3])),
        .in_x     (q_t'(s_axis_tdata[34:19])),
        .in_y     (q_t'(s_axis_tdata[50:35])),
        .in_z     (q_t'(s_axis_tdata[66:51])),
        .cmd      (cmd),
        .out_data (m_axis_tdata)
    );

endmodule

// ===== rtl/qou_checker.sv =====
// port-level checks for the quaternion orientation unit, bound to the top level
// depends on quaternion_orientation_unit
module qou_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [111:0]  m_axis_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transfer withdrawn while stalled");

    // a stalled result keeps its data
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    // one item at a time: busy right after an input transfer
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    // the unit only becomes busy by taking an input transfer
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid))
        else $error("input ready dropped without a transfer");

    // a new result appears together with the return to idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result presented while still busy");

endmodule

bind quaternion_orientation_unit qou_checker u_qou_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/quaternion_orientation_unit_tb.sv =====
// testbench for the quaternion orientation unit: directed and random operation streams
// with a bit-exact predictor of the fixed-point orientation; depends on qou_pkg and the rtl
module quaternion_orientation_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qou_pkg::*;

    typedef struct packed {
        logic signed [15:0] w, x, y, z, vx, vy, vz;
    } pose_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;   // op[2:0], in_w, in_x, in_y, in_z, zero pad
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;   // ori_w, ori_x, ori_y, ori_z, vec_x, vec_y, vec_z

    logic signed [15:0] ori_q [4];
    pose_t  pose_queue [$];
    int     mismatch_count;
    int     hold_cycles;
    bit     idle_on;

    quaternion_orientation_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return 16'(v);
    endfunction

    function automatic longint unsigned root64(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // scale four components to unit length, rounded half away from zero
    task automatic unit_scale(input longint v [4], output logic signed [15:0] o [4]);
        longint unsigned t [4];
        longint unsigned sum, len, q;
        bit neg [4];
        sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            neg[i] = v[i] < 0;
            t[i] = (neg[i] ? longint'(-v[i]) : v[i]) >> 2;
            sum += t[i] * t[i];
        end
        len = root64(sum);
        for (int i = 0; i < 4; i++)
        begin
            q = 0;
            if (len != 0)
                q = (t[i] * 16384 + len / 2) / len;
            if (q > 40000)
                q = 40000;
            o[i] = clamp16(neg[i] ? -longint'(q) : longint'(q));
        end
    endtask

    task automatic hamilton(input logic signed [15:0] a [4], input logic signed [15:0] b [4],
                            output logic signed [15:0] o [4]);
        longint r [4];
        r[0] = longint'(a[0])*b[0] - longint'(a[1])*b[1] - longint'(a[2])*b[2]
             - longint'(a[3])*b[3];
        r[1] = longint'(a[0])*b[1] + longint'(a[1])*b[0] + longint'(a[2])*b[3]
             - longint'(a[3])*b[2];
        r[2] = longint'(a[0])*b[2] + longint'(a[2])*b[0] + longint'(a[3])*b[1]
             - longint'(a[1])*b[3];
        r[3] = longint'(a[0])*b[3] + longint'(a[3])*b[0] + longint'(a[1])*b[2]
             - longint'(a[2])*b[1];
        unit_scale(r, o);
    endtask

    // advance the predicted orientation by one operation
    task automatic predict_pose(input op_t op, input logic signed [15:0] q [4]);
        logic signed [15:0] res [4];
        logic signed [15:0] tmp [4];
        logic signed [15:0] con [4];
        longint wide [4];
        pose_t p;
        p = '0;
        case (op)
            OP_LOAD:   ori_q = q;
            OP_LOCAL:
            begin
                hamilton(q, ori_q, res);
                ori_q = res;
            end
            OP_GLOBAL:
            begin
                hamilton(ori_q, q, res);
                ori_q = res;
            end
            OP_ROTATE:
            begin
                con[0] = ori_q[0];
                for (int i = 1; i < 4; i++)
                    con[i] = clamp16(-longint'(ori_q[i]));
                tmp[0] = 0;
                for (int i = 1; i < 4; i++)
                    tmp[i] = q[i];
                hamilton(con, tmp, res);
                tmp = res;
                hamilton(tmp, ori_q, res);
                p.vx = res[1];
                p.vy = res[2];
                p.vz = res[3];
            end
            OP_CONJ:
                for (int i = 1; i < 4; i++)
                    ori_q[i] = clamp16(-longint'(ori_q[i]));
            OP_NEGATE:
                for (int i = 0; i < 4; i++)
                    ori_q[i] = clamp16(-longint'(ori_q[i]));
            OP_NORM:
            begin
                for (int i = 0; i < 4; i++)
                    wide[i] = longint'(ori_q[i]) * 16384;
                unit_scale(wide, res);
                ori_q = res;
            end
            default: ;
        endcase
        p.w = ori_q[0];
        p.x = ori_q[1];
        p.y = ori_q[2];
        p.z = ori_q[3];
        pose_queue.push_back(p);
    endtask

    // send one transfer, after a random gap while idle_on is set; valid drops only for a gap
    task automatic send_op(input op_t op, input logic [15:0] w, input logic [15:0] x,
                           input logic [15:0] y, input logic [15:0] z);
        logic signed [15:0] q [4];
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, z, y, x, w, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        q[0] = w;
        q[1] = x;
        q[2] = y;
        q[3] = z;
        predict_pose(op, q);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pose_queue.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'(16384);
            3:       return 16'(-16384);
            4:       return 16'($urandom_range(0, 32767) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    // extremes, every operation and the listed corner cases
    task automatic test_directed();
        send_op(OP_NONE, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_op(OP_ROTATE, 0, 16384, 0, 0);
        send_op(OP_NORM, 0, 0, 0, 0);
        send_op(OP_LOAD, 0, 0, 0, 0);
        send_op(OP_NORM, 0, 0, 0, 0);
        send_op(OP_LOCAL, 16384, 0, 0, 0);
        send_op(OP_LOAD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_op(OP_CONJ, 0, 0, 0, 0);
        send_op(OP_NEGATE, 0, 0, 0, 0);
        send_op(OP_LOAD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_op(OP_NORM, 0, 0, 0, 0);
        send_op(OP_GLOBAL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_op(OP_LOCAL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_op(OP_ROTATE, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_op(OP_ROTATE, 16'h7fff, 0, 0, 0);
        send_op(OP_LOAD, 11585, 11585, 0, 0);
        send_op(OP_ROTATE, 0, 0, 16384, 0);
        send_op(OP_GLOBAL, 0, 0, 0, 0);
        send_op(OP_LOCAL, 1, 1, 0, 0);
        send_op(OP_NONE, 0, 0, 0, 0);
        wait_drained();
    endtask

    // random operations with random gaps and stalls
    task automatic test_random(input int count);
        op_t op;
        for (int n = 0; n < count; n++)
        begin
            if (n % 60 == 0)
                idle_on = !idle_on;
            op = op_t'($urandom_range(0, 7));
            send_op(op, rand_comp(), rand_comp(), rand_comp(), rand_comp());
        end
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        hold_cycles = 1500;
        for (int n = 0; n < 6; n++)
            send_op(op_t'($urandom_range(0, 6)), rand_comp(), rand_comp(), rand_comp(),
                    rand_comp());
        wait_drained();
    endtask

    // receiver stall process
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles = $urandom_range(0, 11);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        pose_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                   m_axis_tdata[63:48], m_axis_tdata[79:64], m_axis_tdata[95:80],
                   m_axis_tdata[111:96]};
            if (pose_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer %h", m_axis_tdata);
            end
            else
            begin
                want = pose_queue.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch exp w %0d x %0d y %0d z %0d v %0d %0d %0d got w %0d x %0d y %0d z %0d v %0d %0d %0d",
                                 want.w, want.x, want.y, want.z, want.vx, want.vy, want.vz,
                                 got.w, got.x, got.y, got.z, got.vx, got.vy, got.vz);
                end
            end
        end
    end

    // run limit
    initial
    begin
        #40ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        mismatch_count = 0;
        hold_cycles    = 0;
        idle_on        = 1'b0;
        ori_q[0] = 16384;
        ori_q[1] = 0;
        ori_q[2] = 0;
        ori_q[3] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(200);
        test_backpressure();
        test_random(230);
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && pose_queue.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
